FILE: design/comment_stripping_number_list_parser_macros.svh
// Assertion helpers shared by the parser RTL.
`ifndef COMMENT_STRIPPING_NUMBER_LIST_PARSER_MACROS_SVH
`define COMMENT_STRIPPING_NUMBER_LIST_PARSER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define CSLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define CSLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cslp_pkg.sv
package cslp_pkg;

    localparam int MAX_VALUES_PER_RECORD_DEF = 256;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECORD_START = 2'd1;

    localparam logic [6:0] SEPARATOR_RESET    = 7'd44;  // ','
    localparam logic [6:0] RECORD_START_RESET = 7'd58;  // ':'

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;
    localparam logic [7:0] PRINT_LO   = 8'h21;
    localparam logic [7:0] PRINT_HI   = 8'h7E;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_LINE   = 3'b010,
        MODE_BLOCK  = 3'b100
    } mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [31:0] value;
        logic [7:0]  value_index;
        logic        last_in_record;
        logic        was_hex;
    } out_t;

    typedef struct packed {
        logic [6:0] separator_char;
        logic [6:0] record_start_char;
    } cfg_t;

endpackage

FILE: design/cslp_core.sv
module cslp_core
    import cslp_pkg::*;
#(
    parameter int MAX_VALUES_PER_RECORD = MAX_VALUES_PER_RECORD_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  in_t  item,
    input  cfg_t cfg,
    output logic res_valid,
    output out_t res
);

    localparam int IndexCapInt =
        (MAX_VALUES_PER_RECORD - 1 < 255) ? MAX_VALUES_PER_RECORD - 1 : 255;
    localparam logic [7:0] IndexCap = 8'(IndexCapInt);

    mode_t       mode_reg, mode_next;
    logic        slash_reg, slash_next;
    logic        star_reg, star_next;
    logic        in_rec_reg, in_rec_next;
    logic [31:0] dec_reg, dec_next;
    logic [31:0] hex_reg, hex_next;
    logic [1:0]  pos_reg, pos_next;
    logic        fzero_reg, fzero_next;
    logic        hexm_reg, hexm_next;
    logic [7:0]  idx_reg, idx_next;

    logic [7:0]  b;
    logic        kept;
    logic        handled;
    logic        emit;
    logic        emit_last;
    logic        is_digit;
    logic [3:0]  dd;
    logic [3:0]  hd;

    assign b        = item.data_byte;
    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign dd       = is_digit ? b[3:0] : 4'd0;

    always_comb
    begin
        if (((b >= CHAR_UA) && (b <= CHAR_UF)) || ((b >= CHAR_LA) && (b <= CHAR_LF_HEX)))
        begin
            hd = b[3:0] + 4'd9;
        end
        else
        begin
            hd = dd;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        slash_next  = slash_reg;
        star_next   = star_reg;
        in_rec_next = in_rec_reg;
        dec_next    = dec_reg;
        hex_next    = hex_reg;
        pos_next    = pos_reg;
        fzero_next  = fzero_reg;
        hexm_next   = hexm_reg;
        idx_next    = idx_reg;
        kept        = 1'b0;
        handled     = 1'b0;
        emit        = 1'b0;
        emit_last   = 1'b0;

        if (accept)
        begin
            if (item.end_of_stream)
            begin
                emit      = in_rec_reg;
                emit_last = 1'b1;
            end
            else
            begin
                // comment stripping
                unique case (mode_reg)
                    MODE_LINE:
                    begin
                        if (b == CHAR_LF)
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (star_reg && (b == CHAR_SLASH))
                        begin
                            mode_next = MODE_NORMAL;
                            star_next = 1'b0;
                        end
                        else
                        begin
                            star_next = (b == CHAR_STAR);
                        end
                    end
                    default:
                    begin
                        if (slash_reg)
                        begin
                            slash_next = 1'b0;
                            if (b == CHAR_STAR)
                            begin
                                mode_next = MODE_BLOCK;
                                star_next = 1'b1;
                                handled   = 1'b1;
                            end
                            else if (b == CHAR_SLASH)
                            begin
                                mode_next = MODE_LINE;
                                handled   = 1'b1;
                            end
                        end
                        if (!handled)
                        begin
                            if (b == CHAR_SLASH)
                            begin
                                slash_next = 1'b1;
                            end
                            else
                            begin
                                kept = (b >= PRINT_LO) && (b <= PRINT_HI);
                            end
                        end
                    end
                endcase

                // record parsing on kept characters
                if (kept)
                begin
                    if (!in_rec_reg)
                    begin
                        if (b[6:0] == cfg.record_start_char)
                        begin
                            in_rec_next = 1'b1;
                            idx_next    = 8'd0;
                            dec_next    = 32'd0;
                            hex_next    = 32'd0;
                            pos_next    = 2'd0;
                            fzero_next  = 1'b0;
                            hexm_next   = 1'b0;
                        end
                    end
                    else if (b[6:0] == cfg.separator_char)
                    begin
                        emit = 1'b1;
                    end
                    else if (b[6:0] == cfg.record_start_char)
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                    else
                    begin
                        // x10 as x8 + x2
                        dec_next = {dec_reg[28:0], 3'b000} + {dec_reg[30:0], 1'b0}
                                   + {28'd0, dd};
                        unique case (pos_reg)
                            2'd0:
                            begin
                                fzero_next = (b == CHAR_ZERO);
                                pos_next   = 2'd1;
                            end
                            2'd1:
                            begin
                                hexm_next = fzero_reg && (b == CHAR_X);
                                pos_next  = 2'd2;
                            end
                            default:
                            begin
                                hex_next = {hex_reg[27:0], hd};
                            end
                        endcase
                    end
                end
            end

            if (emit)
            begin
                dec_next   = 32'd0;
                hex_next   = 32'd0;
                pos_next   = 2'd0;
                fzero_next = 1'b0;
                hexm_next  = 1'b0;
                if (emit_last)
                begin
                    idx_next = 8'd0;
                end
                else if (idx_reg < IndexCap)
                begin
                    idx_next = idx_reg + 8'd1;
                end
            end

            if (item.end_of_stream)
            begin
                mode_next   = MODE_NORMAL;
                slash_next  = 1'b0;
                star_next   = 1'b0;
                in_rec_next = 1'b0;
                idx_next    = 8'd0;
                dec_next    = 32'd0;
                hex_next    = 32'd0;
                pos_next    = 2'd0;
                fzero_next  = 1'b0;
                hexm_next   = 1'b0;
            end
        end
    end

    assign res_valid          = emit;
    assign res.value          = hexm_reg ? hex_reg : dec_reg;
    assign res.value_index    = idx_reg;
    assign res.last_in_record = emit_last;
    assign res.was_hex        = hexm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            slash_reg  <= 1'b0;
            star_reg   <= 1'b0;
            in_rec_reg <= 1'b0;
            dec_reg    <= 32'd0;
            hex_reg    <= 32'd0;
            pos_reg    <= 2'd0;
            fzero_reg  <= 1'b0;
            hexm_reg   <= 1'b0;
            idx_reg    <= 8'd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            slash_reg  <= slash_next;
            star_reg   <= star_next;
            in_rec_reg <= in_rec_next;
            dec_reg    <= dec_next;
            hex_reg    <= hex_next;
            pos_reg    <= pos_next;
            fzero_reg  <= fzero_next;
            hexm_reg   <= hexm_next;
            idx_reg    <= idx_next;
        end
    end

`include "comment_stripping_number_list_parser_macros.svh"

    `CSLP_ASSERT_NOW(a_star_only_in_block, clk, rst_n, star_reg, mode_reg == MODE_BLOCK, "star flag outside block comment")
    `CSLP_ASSERT_NOW(a_slash_only_in_text, clk, rst_n, slash_reg, mode_reg == MODE_NORMAL, "pending slash inside comment")
    `CSLP_ASSERT_NEXT(a_eos_clears, clk, rst_n, accept && item.end_of_stream, !in_rec_reg && (mode_reg == MODE_NORMAL) && (idx_reg == 8'd0), "end of stream left state behind")

endmodule

FILE: design/comment_stripping_number_list_parser.sv
// Channel | Dir | Handshake                | Payload
// src     | in  | src_valid / src_stall    | src_data  (data_byte, end_of_stream)
// res     | out | res_valid / res_stall    | res_data  (value, value_index,
//         |     |                          |            last_in_record, was_hex)
// cfg     | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One request per clock while src_stall is low; the parser state updates in the cycle
// a request is taken. A result is registered (output register or skid) before res.
// The two-entry output buffer (output register + skid) sets the stall: src_stall
// rises only when both entries hold results that downstream has not taken.
// Asynchronous active-low reset restores the separator (',') and record start (':'),
// returns the parser to normal text, seeking a record start; no clearing pass.
module comment_stripping_number_list_parser
    import cslp_pkg::*;
#(
    parameter int MAX_VALUES_PER_RECORD = MAX_VALUES_PER_RECORD_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    output logic                   src_stall,
    input  in_t                    src_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output out_t                   res_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [6:0]             cfg_data
);

    logic [6:0] sep_char_reg, sep_char_next;
    logic [6:0] rs_char_reg, rs_char_next;
    cfg_t       cfg;

    logic       out_valid_reg, out_valid_next;
    out_t       out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    out_t       skid_data_reg, skid_data_next;

    logic       accept;
    logic       take;
    logic       core_valid;
    out_t       core_res;

    // configuration registers; always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        sep_char_next = sep_char_reg;
        rs_char_next  = rs_char_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SEPARATOR:    sep_char_next = cfg_data;
                REG_RECORD_START: rs_char_next  = cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg.separator_char    = sep_char_reg;
    assign cfg.record_start_char = rs_char_reg;

    // request handshake
    assign src_stall = skid_valid_reg;
    assign accept    = src_valid && !src_stall;

    cslp_core #(
        .MAX_VALUES_PER_RECORD (MAX_VALUES_PER_RECORD)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (src_data),
        .cfg       (cfg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    // output register with skid entry behind it
    assign take = out_valid_reg && !res_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (core_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = core_res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = core_res;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_char_reg   <= SEPARATOR_RESET;
            rs_char_reg    <= RECORD_START_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            sep_char_reg   <= sep_char_next;
            rs_char_reg    <= rs_char_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

`include "comment_stripping_number_list_parser_macros.svh"

    `CSLP_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry held with empty output register")
    `CSLP_ASSERT_NOW(a_core_only_on_accept, clk, rst_n, core_valid, accept,
        "result produced without an accepted request")
    `CSLP_ASSERT_NEXT(a_spill_to_skid, clk, rst_n, core_valid && out_valid_reg && res_stall,
        skid_valid_reg, "stalled result not captured in skid")

endmodule

FILE: tb/comment_stripping_number_list_parser_tb.sv
module comment_stripping_number_list_parser_tb
    import cslp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Highest value_index before it saturates: min(MAX_VALUES_PER_RECORD - 1, 255).
    localparam int VALUE_INDEX_CAP =
        (MAX_VALUES_PER_RECORD_DEF - 1 < 255) ? MAX_VALUES_PER_RECORD_DEF - 1 : 255;
    // Cycles to let pass after the last expected result before a register write.
    localparam int SETTLE_CYCLES = 8;
    // Upper bound on the wait for outstanding results in one drain.
    localparam int DRAIN_GUARD = 20000;
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // DUT signals. Everything driven by the bench starts at a known value.
    // ------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   src_valid = 1'b0;
    logic                   src_stall;
    in_t                    src_data = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    out_t                   res_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [6:0]             cfg_data = '0;

    comment_stripping_number_list_parser #(
        .MAX_VALUES_PER_RECORD(MAX_VALUES_PER_RECORD_DEF)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    in_t  pending_reqs[$];     // requests waiting to be driven
    out_t expected_values[$];  // parsed values still owed by the DUT

    int   src_idle_pct = 0;    // chance (of 100) the driver leaves a cycle empty
    int   res_stall_pct = 0;   // chance (of 100) the receiver stalls
    bit   req_taken = 1'b0;    // request accepted at the last rising edge

    int   n_reqs = 0;
    int   n_results = 0;
    int   n_hex = 0;
    int   n_last = 0;
    int   n_capped = 0;
    int   n_cfg_writes = 0;
    int   n_errors = 0;

    // ------------------------------------------------------------------
    // Parser prediction: comment stripping, record framing, token
    // accumulation. Blocking updates, called once per accepted request.
    // ------------------------------------------------------------------
    mode_t       cm_mode;
    logic        slash_hold;   // '/' seen in text, waiting for the next byte
    logic        star_hold;    // last byte inside a block comment was '*'
    logic        rec_open;     // first record start has been seen
    logic [31:0] dec_sum;
    logic [31:0] hex_sum;
    logic [1:0]  tok_pos;      // chars into the token: 0, 1, then stuck at 2
    logic        lead_zero;
    logic        hex_tok;
    logic [7:0]  val_idx;
    logic [6:0]  sep_char;
    logic [6:0]  start_char;

    function automatic void clear_token();
        dec_sum   = '0;
        hex_sum   = '0;
        tok_pos   = '0;
        lead_zero = 1'b0;
        hex_tok   = 1'b0;
    endfunction

    function automatic void restart_stream();
        cm_mode    = MODE_NORMAL;
        slash_hold = 1'b0;
        star_hold  = 1'b0;
        rec_open   = 1'b0;
        val_idx    = '0;
        clear_token();
    endfunction

    // Returns 1 when the byte survives comment stripping and the printable filter.
    function automatic logic keep_char(input logic [7:0] b);
        if (cm_mode == MODE_LINE)
        begin
            if (b == CHAR_LF)
                cm_mode = MODE_NORMAL;
            return 1'b0;
        end
        if (cm_mode == MODE_BLOCK)
        begin
            // the opening '*' is already in star_hold, so "/*/" closes at once
            if (star_hold && b == CHAR_SLASH)
            begin
                cm_mode   = MODE_NORMAL;
                star_hold = 1'b0;
            end
            else
                star_hold = (b == CHAR_STAR);
            return 1'b0;
        end
        if (slash_hold)
        begin
            slash_hold = 1'b0;
            if (b == CHAR_STAR)
            begin
                cm_mode   = MODE_BLOCK;
                star_hold = 1'b1;
                return 1'b0;
            end
            if (b == CHAR_SLASH)
            begin
                cm_mode = MODE_LINE;
                return 1'b0;
            end
            // lone slash falls away, this byte is handled normally
        end
        if (b == CHAR_SLASH)
        begin
            slash_hold = 1'b1;
            return 1'b0;
        end
        return (b >= PRINT_LO && b <= PRINT_HI);
    endfunction

    function automatic void add_char(input logic [7:0] c);
        logic [31:0] dd;
        logic [31:0] hd;
        dd = (c >= CHAR_ZERO && c <= CHAR_NINE) ? 32'(c - CHAR_ZERO) : 32'd0;
        dec_sum = dec_sum * 32'd10 + dd;
        if (tok_pos == 2'd0)
        begin
            lead_zero = (c == CHAR_ZERO);
            tok_pos   = 2'd1;
        end
        else if (tok_pos == 2'd1)
        begin
            hex_tok = lead_zero && (c == CHAR_X);
            tok_pos = 2'd2;
        end
        else
        begin
            if (c >= CHAR_UA && c <= CHAR_UF)
                hd = 32'(c - CHAR_UA) + 32'd10;
            else if (c >= CHAR_LA && c <= CHAR_LF_HEX)
                hd = 32'(c - CHAR_LA) + 32'd10;
            else
                hd = dd;
            hex_sum = hex_sum * 32'd16 + hd;
        end
    endfunction

    function automatic void emit_value(input logic last);
        out_t r;
        r.value          = hex_tok ? hex_sum : dec_sum;
        r.value_index    = val_idx;
        r.last_in_record = last;
        r.was_hex        = hex_tok;
        expected_values.push_back(r);
        clear_token();
        if (last)
            val_idx = '0;
        else if (val_idx < 8'(VALUE_INDEX_CAP))
            val_idx = val_idx + 8'd1;
    endfunction

    function automatic void parse_request(input in_t req);
        if (req.end_of_stream)
        begin
            if (rec_open)
                emit_value(1'b1);
            restart_stream();
        end
        else if (keep_char(req.data_byte))
        begin
            if (!rec_open)
            begin
                if (req.data_byte == {1'b0, start_char})
                begin
                    rec_open = 1'b1;
                    val_idx  = '0;
                    clear_token();
                end
            end
            // separator wins when both registers hold the same code
            else if (req.data_byte == {1'b0, sep_char})
                emit_value(1'b0);
            else if (req.data_byte == {1'b0, start_char})
                emit_value(1'b1);
            else
                add_char(req.data_byte);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: changes inputs at the falling edge only. A request stays on
    // the bus until the monitor saw it accepted.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            res_stall <= 1'b0;
        end
        else
        begin
            if (!src_valid || req_taken)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    src_valid <= 1'b1;
                    src_data  <= pending_reqs.pop_front();
                end
                else
                    src_valid <= 1'b0;
            end
            res_stall <= ($urandom_range(99) < res_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge. The result is checked before the
    // request of the same edge is predicted, since a result always trails
    // its request through the DUT's output register.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("Unexpected result: value=%h index=%0d last=%b hex=%b",
                                 res_data.value, res_data.value_index,
                                 res_data.last_in_record, res_data.was_hex);
                end
                else
                begin
                    out_t want;
                    want = expected_values.pop_front();
                    if (res_data.value !== want.value
                        || res_data.value_index !== want.value_index
                        || res_data.last_in_record !== want.last_in_record
                        || res_data.was_hex !== want.was_hex)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display({"Mismatch at result %0d: expected value=%h index=%0d ",
                                      "last=%b hex=%b, got value=%h index=%0d last=%b hex=%b"},
                                     n_results, want.value, want.value_index,
                                     want.last_in_record, want.was_hex,
                                     res_data.value, res_data.value_index,
                                     res_data.last_in_record, res_data.was_hex);
                    end
                    n_hex    += want.was_hex;
                    n_last   += want.last_in_record;
                    n_capped += (want.value_index == 8'(VALUE_INDEX_CAP));
                end
                n_results++;
            end
            if (src_valid && !src_stall)
            begin
                parse_request(src_data);
                req_taken = 1'b1;
                n_reqs++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders (no time passes while the queue is filled)
    // ------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        in_t r;
        r.data_byte     = b;
        r.end_of_stream = 1'b0;
        pending_reqs.push_back(r);
    endfunction

    // data_byte is don't-care under end_of_stream; randomize it anyway
    function automatic void push_eos();
        in_t r;
        r.data_byte     = 8'($urandom_range(255));
        r.end_of_stream = 1'b1;
        pending_reqs.push_back(r);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_digits(input int n);
        repeat (n)
            push_byte(CHAR_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void push_token();
        string hexset;
        hexset = "0123456789abcdefABCDEFgx";
        case ($urandom_range(5))
            0: push_digits($urandom_range(1, 12));          // decimal, may wrap
            1:
            begin
                push_byte(CHAR_ZERO);
                // an upper-case X does not count as the hex prefix
                push_byte(($urandom_range(9) == 0) ? 8'h58 : CHAR_X);
                repeat ($urandom_range(0, 10))
                    push_byte(hexset[$urandom_range(hexset.len() - 1)]);
            end
            2: ;                                             // empty token
            3:
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(8'h21, 8'h7E)));
            4:
            begin
                push_digits($urandom_range(1, 3));
                if ($urandom_range(1))
                begin
                    push_text("/*");
                    repeat ($urandom_range(0, 4))
                        push_byte(8'($urandom_range(255)));
                    push_text("*/");
                end
                else
                begin
                    push_text("//");
                    repeat ($urandom_range(0, 4))
                        push_byte(8'($urandom_range(8'h20, 8'h7E)));
                    push_byte(CHAR_LF);
                end
                push_digits($urandom_range(0, 3));
            end
            default:
            begin
                // digits with blanks and control bytes mixed in
                repeat ($urandom_range(1, 5))
                begin
                    if ($urandom_range(2) == 0)
                        push_byte(($urandom_range(1)) ? 8'h20 : 8'($urandom_range(8'h1F)));
                    push_digits(1);
                end
            end
        endcase
    endfunction

    // One record: start char, a few values, then maybe end of stream.
    function automatic void push_record();
        int n_vals;
        n_vals = $urandom_range(1, 6);
        push_byte({1'b0, start_char});
        for (int v = 0; v < n_vals; v++)
        begin
            push_token();
            if (v < n_vals - 1)
                push_byte({1'b0, sep_char});
        end
        if ($urandom_range(3) == 0)
            push_eos();
    endfunction

    function automatic void push_noise();
        repeat ($urandom_range(1, 8))
            case ($urandom_range(5))
                0, 1: push_byte(8'($urandom_range(255)));
                2: push_byte(CHAR_SLASH);
                3: push_byte(CHAR_STAR);
                4: push_byte(CHAR_LF);
                default: push_eos();
            endcase
    endfunction

    // ------------------------------------------------------------------
    // Phase control
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [6:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SEPARATOR)
            sep_char = val;
        else if (idx == REG_RECORD_START)
            start_char = val;
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request went in and every result came back (or the guard ran out),
    // then let the parser settle so a register write lands on an idle block.
    task automatic drain_parser();
        int guard;
        guard = 0;
        while (pending_reqs.size() != 0 || src_valid)
            @(posedge clk);
        while (expected_values.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int src_pct, input int res_pct, input int n_items);
        src_idle_pct  = src_pct;
        res_stall_pct = res_pct;
        while (pending_reqs.size() < n_items)
        begin
            if ($urandom_range(99) < 80)
                push_record();
            else
                push_noise();
        end
        drain_parser();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sep_char   = SEPARATOR_RESET;
        start_char = RECORD_START_RESET;
        restart_stream();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset registers (',' and ':'):
        //   junk before the first record start, a bare "0x" token, an empty
        //   token, slash-star-slash comment, hex with dropped control bytes,
        //   a line comment, a slash left pending at end of stream, and an
        //   end of stream with no record open.
        push_byte(8'h00);
        push_text("5:0x,,/*/0xFf");
        push_byte(8'h7F);
        push_byte(8'hFF);
        push_text(" ://~");
        push_byte(CHAR_LF);
        push_text("9/");
        push_eos();
        push_eos();
        run_phase(0, 0, 0);

        // One long record to run value_index into saturation.
        push_byte({1'b0, start_char});
        repeat (265)
        begin
            if ($urandom_range(3) == 0)
                push_digits(1);
            push_byte({1'b0, sep_char});
        end
        push_eos();
        run_phase(0, 0, 340);

        // Register extremes, swapped roles, equal codes, unmatchable codes.
        write_reg(REG_SEPARATOR, 7'h21);
        write_reg(REG_RECORD_START, 7'h7E);
        run_phase(66, 0, 120);

        write_reg(REG_SEPARATOR, 7'h7E);
        write_reg(REG_RECORD_START, 7'h21);
        run_phase(0, 66, 120);

        write_reg(REG_SEPARATOR, 7'h3B);
        write_reg(REG_RECORD_START, 7'h3B);
        run_phase(13, 13, 120);

        // separator never matches: one value per record
        write_reg(REG_SEPARATOR, 7'h7F);
        write_reg(REG_RECORD_START, RECORD_START_RESET);
        run_phase(0, 0, 80);

        // record start never matches: no new record opens, only one left open can emit
        write_reg(REG_SEPARATOR, SEPARATOR_RESET);
        write_reg(REG_RECORD_START, 7'h00);
        run_phase(66, 0, 40);

        write_reg(REG_RECORD_START, RECORD_START_RESET);
        run_phase(0, 66, 120);

        // anything still owed at this point never arrived
        n_errors += expected_values.size();

        $display("Drove %0d requests through %0d register writes and four idle patterns",
                 n_reqs, n_cfg_writes);
        $display("Checked %0d values: %0d hex, %0d record ends, %0d at the index cap; %0d errors",
                 n_results, n_hex, n_last, n_capped, n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d requests queued and %0d results owed",
                 pending_reqs.size(), expected_values.size());
        $display("Verification failed");
        $finish;
    end

endmodule
